// ===== rtl/pairwise_pull_velocity_update_defines.svh =====
// Assertion macros for the pairwise pull velocity update block
`ifndef PAIRWISE_PULL_VELOCITY_UPDATE_DEFINES_SVH
`define PAIRWISE_PULL_VELOCITY_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define PPVU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define PPVU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ppvu_pkg.sv =====
// Shared types and constants of the pairwise pull velocity update block
package ppvu_pkg;

  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 4;
  localparam int ACC_W     = 54;
  localparam int P_W       = 110;

  localparam logic [CFG_IDX_W-1:0] REG_PULL_SCALE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FACTOR = CFG_IDX_W'(1);

  localparam logic [31:0] PULL_SCALE_RST  = 32'd4295;
  localparam logic [7:0]  RATE_FACTOR_RST = 8'd60;

  typedef enum logic [1:0] {
    DIV_UX  = 2'd0,
    DIV_UY  = 2'd1,
    DIV_DVX = 2'd2,
    DIV_DVY = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] m;
    logic [31:0] vx;
    logic [31:0] vy;
  } body_t;

  typedef struct packed {
    logic     accept;
    logic     rd_own;
    logic     lat_own;
    logic     rd_pair;
    logic     lat_pair;
    logic     sq;
    logic     set_coin;
    logic     sqrt_go;
    logic     div_go;
    div_sel_t div_sel;
    logic     save_div;
    logic     term;
    logic     acc;
    logic     inc_j;
    logic     inc_i;
    logic     mul;
    logic     axis_y;
    logic     emit;
    logic     frame_end;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic coin;
    logic j_eq_i;
    logic j_last;
    logic i_last;
    logic mul_last;
  } status_t;

endpackage

// ===== rtl/ppvu_isqrt.sv =====
// Iterative floor square root, two radicand bits per cycle
module ppvu_isqrt import ppvu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [34:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  assign rem_sh = {rem[32:0], rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one root digit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad <= {rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/ppvu_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
module ppvu_div import ppvu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [31:0] dsr;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] rem_sh;
  logic        fit;

  assign rem_sh = {rem, quotient[63]};
  assign fit    = rem_sh >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-subtract step; dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (run) begin
      rem      <= fit ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
      quotient <= {quotient[62:0], fit};
    end
  end

endmodule

// ===== rtl/ppvu_ctrl.sv =====
// Sequencer: frame load, pair loop per body, velocity scaling, result emit
module ppvu_ctrl import ppvu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    last_body,
  input  status_t st,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [21:0] {
    S_LOAD      = 22'd1 << 0,
    S_OWN_RD    = 22'd1 << 1,
    S_OWN_LAT   = 22'd1 << 2,
    S_PAIR_RD   = 22'd1 << 3,
    S_PAIR_LAT  = 22'd1 << 4,
    S_SQ        = 22'd1 << 5,
    S_SQRT_GO   = 22'd1 << 6,
    S_SQRT_WAIT = 22'd1 << 7,
    S_DIVX_GO   = 22'd1 << 8,
    S_DIVX_WAIT = 22'd1 << 9,
    S_DIVY_GO   = 22'd1 << 10,
    S_DIVY_WAIT = 22'd1 << 11,
    S_TERM      = 22'd1 << 12,
    S_ACC       = 22'd1 << 13,
    S_NEXT_J    = 22'd1 << 14,
    S_MULX      = 22'd1 << 15,
    S_DVX_GO    = 22'd1 << 16,
    S_DVX_WAIT  = 22'd1 << 17,
    S_MULY      = 22'd1 << 18,
    S_DVY_GO    = 22'd1 << 19,
    S_DVY_WAIT  = 22'd1 << 20,
    S_EMIT      = 22'd1 << 21
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_LOAD);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (last_body) state_next = S_OWN_RD;
        end
      end
      S_OWN_RD: begin
        cmd.rd_own = 1'b1;
        state_next = S_OWN_LAT;
      end
      S_OWN_LAT: begin
        cmd.lat_own = 1'b1;
        state_next  = S_PAIR_RD;
      end
      S_PAIR_RD: begin
        // a body exerts no pull on itself
        if (st.j_eq_i) begin
          if (st.j_last) state_next = S_MULX;
          else cmd.inc_j = 1'b1;
        end else begin
          cmd.rd_pair = 1'b1;
          state_next  = S_PAIR_LAT;
        end
      end
      S_PAIR_LAT: begin
        cmd.lat_pair = 1'b1;
        state_next   = S_SQ;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (st.coin) begin
          cmd.set_coin = 1'b1;
          state_next   = S_NEXT_J;
        end else begin
          state_next = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd.sqrt_go = 1'b1;
        state_next  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (st.sqrt_done) state_next = S_DIVX_GO;
      end
      S_DIVX_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_UX;
        state_next  = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: begin
        cmd.div_sel = DIV_UX;
        if (st.div_done) begin
          cmd.save_div = 1'b1;
          state_next   = S_DIVY_GO;
        end
      end
      S_DIVY_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_UY;
        state_next  = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: begin
        cmd.div_sel = DIV_UY;
        if (st.div_done) begin
          cmd.save_div = 1'b1;
          state_next   = S_TERM;
        end
      end
      S_TERM: begin
        cmd.term   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_NEXT_J;
      end
      S_NEXT_J: begin
        if (st.j_last) begin
          state_next = S_MULX;
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = S_PAIR_RD;
        end
      end
      S_MULX: begin
        cmd.mul = 1'b1;
        if (st.mul_last) state_next = S_DVX_GO;
      end
      S_DVX_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_DVX;
        state_next  = S_DVX_WAIT;
      end
      S_DVX_WAIT: begin
        cmd.div_sel = DIV_DVX;
        if (st.div_done) begin
          cmd.save_div = 1'b1;
          state_next   = S_MULY;
        end
      end
      S_MULY: begin
        cmd.mul    = 1'b1;
        cmd.axis_y = 1'b1;
        if (st.mul_last) state_next = S_DVY_GO;
      end
      S_DVY_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_DVY;
        state_next  = S_DVY_WAIT;
      end
      S_DVY_WAIT: begin
        cmd.div_sel = DIV_DVY;
        if (st.div_done) begin
          cmd.save_div = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.i_last) begin
          cmd.frame_end = 1'b1;
          state_next    = S_LOAD;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = S_OWN_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/ppvu_datapath.sv =====
// Body store, pair arithmetic, accumulators, velocity scaling and result registers
module ppvu_datapath import ppvu_pkg::*; #(
  parameter int MAX_BODIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              st,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic [31:0]          body_mass,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  input  logic [15:0]          time_step,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 result_valid,
  output logic [IDX_W-1:0]     body_index,
  output logic signed [31:0]   new_vel_x,
  output logic signed [31:0]   new_vel_y,
  output logic                 coincident_seen,
  output logic                 zero_mass,
  output logic                 overflowed,
  output logic                 last_result
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BODIES);

  // configuration and frame control
  logic [31:0]   pull_scale;
  logic [7:0]    rate_factor;
  logic [CW-1:0] count;
  logic          ovf;
  logic [AW-1:0] i_idx, j_idx;
  logic [1:0]    mstep;

  // body store
  body_t         mem [MAX_BODIES];
  body_t         rdata;
  logic [AW-1:0] raddr;

  // working registers
  body_t             own;
  logic [23:0]       k;
  logic [55:0]       tprod;
  logic              sx, sy, pcoin, coin;
  logic [30:0]       mx, my;
  logic [31:0]       om;
  logic [61:0]       sqx, sqy;
  logic [30:0]       ux, uy;
  logic [62:0]       px, py;
  logic [ACC_W-1:0]  ax, ay;
  logic [P_W-1:0]    prod_acc;
  logic [62:0]       qx, qy;

  // combinational helpers
  logic [32:0]       dx, dy, adx, ady;
  logic              half;
  logic [62:0]       sq_sum;
  logic [31:0]       root, span;
  logic              sqrt_done, div_done;
  logic [63:0]       div_a, quo;
  logic [31:0]       div_b;
  logic [ACC_W-1:0]  abs_x, abs_y, abs_a;
  logic [26:0]       a_chunk;
  logic [27:0]       t_chunk;
  logic [54:0]       part;
  logic [6:0]        sh;
  logic [P_W-1:0]    part_sh;
  logic              own_zero;

  function automatic logic [31:0] sat_add(input logic [31:0] v, input logic neg,
                                          input logic [62:0] q);
    logic [64:0] d;
    logic [64:0] s;
    d = neg ? (65'd0 - {2'b00, q}) : {2'b00, q};
    s = {{33{v[31]}}, v} + d;
    if (!s[64] && (s[63:31] != '0)) begin
      sat_add = 32'h7FFF_FFFF;
    end else if (s[64] && (s[63:31] != '1)) begin
      sat_add = 32'h8000_0000;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // status back to the sequencer
  assign st.sqrt_done = sqrt_done;
  assign st.div_done  = div_done;
  assign st.coin      = pcoin;
  assign st.j_eq_i    = (j_idx == i_idx);
  assign st.j_last    = (CW'(j_idx) + CW'(1)) == count;
  assign st.i_last    = (CW'(i_idx) + CW'(1)) == count;
  assign st.mul_last  = (mstep == 2'd3);

  // store write on accept, registered read
  assign raddr = cmd.rd_own ? i_idx : j_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept && (count < MAX_CNT)) begin
      mem[count[AW-1:0]] <= '{x: pos_x, y: pos_y, m: body_mass, vx: vel_x, vy: vel_y};
    end
    rdata <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pull_scale   <= PULL_SCALE_RST;
      rate_factor  <= RATE_FACTOR_RST;
      count        <= '0;
      ovf          <= 1'b0;
      i_idx        <= '0;
      j_idx        <= '0;
      mstep        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cfg_valid) begin
        case (cfg_index)
          REG_PULL_SCALE:  pull_scale  <= cfg_data;
          REG_RATE_FACTOR: rate_factor <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (count < MAX_CNT) count <= count + CW'(1);
        else ovf <= 1'b1;
      end
      if (cmd.frame_end) begin
        count <= '0;
        ovf   <= 1'b0;
        i_idx <= '0;
      end else if (cmd.inc_i) begin
        i_idx <= i_idx + AW'(1);
      end
      if (cmd.lat_own) j_idx <= '0;
      else if (cmd.inc_j) j_idx <= j_idx + AW'(1);
      mstep <= cmd.mul ? mstep + 2'd1 : 2'd0;
    end
  end

  // pair difference, magnitude, and halving of large spans
  assign dx   = {rdata.x[31], rdata.x} - {own.x[31], own.x};
  assign dy   = {rdata.y[31], rdata.y} - {own.y[31], own.y};
  assign adx  = dx[32] ? (33'd0 - dx) : dx;
  assign ady  = dy[32] ? (33'd0 - dy) : dy;
  assign half = adx[31] | ady[31];

  assign sq_sum = {1'b0, sqx} + {1'b0, sqy};
  assign span   = (root == '0) ? 32'd1 : root;

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      DIV_UX:  begin div_a = {3'b000, mx, 30'd0}; div_b = span; end
      DIV_UY:  begin div_a = {3'b000, my, 30'd0}; div_b = span; end
      DIV_DVX: begin div_a = {1'b0, prod_acc[108:46]}; div_b = own.m; end
      DIV_DVY: begin div_a = {1'b0, prod_acc[108:46]}; div_b = own.m; end
      default: begin div_a = '0; div_b = 32'd1; end
    endcase
  end

  ppvu_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_go),
    .radicand ({1'b0, sq_sum}),
    .done     (sqrt_done),
    .root     (root)
  );

  ppvu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  // |A| * (pull_scale * k) as four 27x28 partial products
  assign abs_x   = ax[ACC_W-1] ? (ACC_W'(0) - ax) : ax;
  assign abs_y   = ay[ACC_W-1] ? (ACC_W'(0) - ay) : ay;
  assign abs_a   = cmd.axis_y ? abs_y : abs_x;
  assign a_chunk = mstep[1] ? abs_a[53:27] : abs_a[26:0];
  assign t_chunk = mstep[0] ? tprod[55:28] : tprod[27:0];
  assign part    = 55'(a_chunk) * 55'(t_chunk);
  assign sh      = (mstep[1] ? 7'd27 : 7'd0) + (mstep[0] ? 7'd28 : 7'd0);
  assign part_sh = P_W'(part) << sh;

  assign own_zero = (own.m == '0);

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.accept) k <= 24'(time_step) * 24'(rate_factor);
    if (cmd.lat_own) begin
      own   <= rdata;
      ax    <= '0;
      ay    <= '0;
      coin  <= 1'b0;
      tprod <= 56'(pull_scale) * 56'(k);
    end
    if (cmd.lat_pair) begin
      sx    <= dx[32];
      sy    <= dy[32];
      mx    <= half ? adx[31:1] : adx[30:0];
      my    <= half ? ady[31:1] : ady[30:0];
      om    <= rdata.m;
      pcoin <= (dx == '0) && (dy == '0);
    end
    if (cmd.sq) begin
      sqx <= 62'(mx) * 62'(mx);
      sqy <= 62'(my) * 62'(my);
    end
    if (cmd.set_coin) coin <= 1'b1;
    if (cmd.save_div) begin
      case (cmd.div_sel)
        DIV_UX:  ux <= quo[30:0];
        DIV_UY:  uy <= quo[30:0];
        DIV_DVX: qx <= quo[62:0];
        DIV_DVY: qy <= quo[62:0];
        default: ;
      endcase
    end
    if (cmd.term) begin
      px <= 63'(ux) * 63'(om);
      py <= 63'(uy) * 63'(om);
    end
    if (cmd.acc) begin
      ax <= sx ? (ax - ACC_W'(px[62:16])) : (ax + ACC_W'(px[62:16]));
      ay <= sy ? (ay - ACC_W'(py[62:16])) : (ay + ACC_W'(py[62:16]));
    end
    if (cmd.mul) begin
      prod_acc <= ((mstep == 2'd0) ? P_W'(0) : prod_acc) + part_sh;
    end
    // result registers
    if (cmd.emit) begin
      body_index      <= IDX_W'(i_idx);
      new_vel_x       <= own_zero ? own.vx : sat_add(own.vx, ax[ACC_W-1], qx);
      new_vel_y       <= own_zero ? own.vy : sat_add(own.vy, ay[ACC_W-1], qy);
      coincident_seen <= coin;
      zero_mass       <= own_zero;
      overflowed      <= ovf;
      last_result     <= st.i_last;
    end
  end

endmodule

// ===== rtl/pairwise_pull_velocity_update.sv =====
// Top level of the pairwise pull velocity update block
// Usage:
//  Bodies arrive as requests on start while busy is low, one per cycle if
//  wanted; each is stored in load order. Requests past MAX_BODIES are dropped
//  and flagged. A request with last_body set ends the frame: busy rises and
//  the block works through the pairs of each body in load order and emits
//  that body's result before the next, each shown for one cycle with
//  result_valid; last_result marks the final one. The receiver cannot stall,
//  so results are never held. Work: a non-coincident pair runs one 32-step
//  square root and two 64-step divides in shared iterative units; a
//  coincident pair skips them. Per body, own fetch, self skip, velocity
//  scaling and emit add two 64-step divides by own mass. Busy falls in the
//  cycle that shows the last result, when the next frame may begin.
//  Configuration writes (index 0 pull_scale, 1 rate_factor) are ready only
//  while busy is low. Synchronous reset empties the frame, drops busy and
//  loads the register defaults; stored bodies are not cleared.
`include "pairwise_pull_velocity_update_defines.svh"

module pairwise_pull_velocity_update import ppvu_pkg::*; #(
  parameter int MAX_BODIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic [31:0]          body_mass,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  input  logic [15:0]          time_step,
  input  logic                 last_body,
  output logic                 result_valid,
  output logic [IDX_W-1:0]     body_index,
  output logic signed [31:0]   new_vel_x,
  output logic signed [31:0]   new_vel_y,
  output logic                 coincident_seen,
  output logic                 zero_mass,
  output logic                 overflowed,
  output logic                 last_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t    cmd;
  status_t st;

  // registers change only between frames
  assign cfg_ready = !busy;

  ppvu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_body (last_body),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy)
  );

  ppvu_datapath #(
    .MAX_BODIES (MAX_BODIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .body_mass       (body_mass),
    .vel_x           (vel_x),
    .vel_y           (vel_y),
    .time_step       (time_step),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .result_valid    (result_valid),
    .body_index      (body_index),
    .new_vel_x       (new_vel_x),
    .new_vel_y       (new_vel_y),
    .coincident_seen (coincident_seen),
    .zero_mass       (zero_mass),
    .overflowed      (overflowed),
    .last_result     (last_result)
  );

  // results only come out of a frame in progress
  `PPVU_ASSERT_NOW(a_result_in_frame, result_valid, $past(busy), "result outside a frame")
  // a body that does not end the frame keeps the block loading
  `PPVU_ASSERT_NEXT(a_load_stays, start && !busy && !last_body, !busy, "busy after plain body")
  // the final body starts the frame computation
  `PPVU_ASSERT_NEXT(a_last_starts, start && !busy && last_body, busy, "frame did not start")
  // the frame is released when its final result shows
  `PPVU_ASSERT_NOW(a_last_frees, result_valid && last_result, !busy, "busy at last result")

endmodule
